// ===== sv/fasn_pkg.sv =====
// ----------------------------------------------------------------------------
// fasn_pkg
// shared types and constants for the bit-serial float add/sub normalizer
// ----------------------------------------------------------------------------
package fasn_pkg;

   localparam int FRAC_BITS  = 23;
   localparam int EXP_BITS   = 8;

   // datapath: carry bit, hidden one, 2*FRAC_BITS fraction bits
   localparam int DP_W       = 2 * FRAC_BITS + 2;
   localparam int CNT_W      = $clog2(DP_W + 1);
   localparam int SHIFT_W    = $clog2(DP_W);
   localparam int EXP_CALC_W = ((EXP_BITS > SHIFT_W) ? EXP_BITS : SHIFT_W) + 2;

   localparam logic signed [EXP_CALC_W-1:0] EXP_MIN =
      EXP_CALC_W'(-(2 ** (EXP_BITS - 1)));
   localparam logic signed [EXP_CALC_W-1:0] EXP_MAX =
      EXP_CALC_W'((2 ** (EXP_BITS - 1)) - 1);

   typedef enum logic [1:0] {
      ST_NORMAL = 2'd0,
      ST_ZERO   = 2'd1,
      ST_UNDER  = 2'd2,
      ST_OVER   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALIGN,
      S_ADD,
      S_NORM,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [FRAC_BITS-1:0] frac_a;
      logic [EXP_BITS-1:0]  exp_a;
      logic [FRAC_BITS-1:0] frac_b;
      logic [EXP_BITS-1:0]  exp_b;
      logic                 is_add;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic                       result_negative;
      logic [FRAC_BITS-1:0]       result_fraction;
      logic signed [EXP_BITS-1:0] result_exponent;
   } rsp_type;

   // control of the serial adder cell
   typedef struct packed {
      logic clear;
      logic enable;
      logic subtract;
   } adder_ctl_type;

endpackage

// ===== sv/fasn_serial_adder.sv =====
// ----------------------------------------------------------------------------
// fasn_serial_adder
// one-bit adder/subtractor cell with carry register, lsb first
// ----------------------------------------------------------------------------
module fasn_serial_adder (
   input  logic                    clock,
   input  fasn_pkg::adder_ctl_type ctl,
   input  logic                    a_bit,
   input  logic                    b_bit,
   output logic                    sum_bit
);

   logic carry_ff;
   logic carry_in;
   logic b_eff;

   // subtract as a + ~b + 1, the +1 comes from the preset carry
   assign b_eff   = b_bit ^ ctl.subtract;
   assign sum_bit = a_bit ^ b_eff ^ carry_ff;

   always_comb begin
      carry_in = carry_ff;
      if (ctl.clear) begin
         carry_in = ctl.subtract;
      end else if (ctl.enable) begin
         carry_in = (a_bit & b_eff) | (a_bit & carry_ff) | (b_eff & carry_ff);
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
   end

endmodule

// ===== sv/float_add_sub_normalize.sv =====
// ----------------------------------------------------------------------------
// float_add_sub_normalize
// bit-serial floating-point add/subtract with alignment and normalization
// ----------------------------------------------------------------------------
// sequence: accept, align shifts, a serial add over every datapath bit, then
//   normalize shifts and the done state; a zero result skips the normalize state
//   (align shift capped at the 48-bit datapath width)
// one request at a time: busy drops in the cycle the result strobe is shown
// reset: synchronous, active high; returns to idle with no result pending
// the result is shown for one cycle on rsp_valid and cannot be held off
module float_add_sub_normalize (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              start,
   output logic              busy,
   input  fasn_pkg::req_type req_data,
   // result channel
   output logic              rsp_valid,
   output fasn_pkg::rsp_type rsp_data
);

   localparam int DP_W  = fasn_pkg::DP_W;
   localparam int CNT_W = fasn_pkg::CNT_W;
   localparam int EW    = fasn_pkg::EXP_CALC_W;
   localparam int FB    = fasn_pkg::FRAC_BITS;
   localparam int EB    = fasn_pkg::EXP_BITS;
   localparam int CMP_W = EB + CNT_W;

   fasn_pkg::state_type state_ff, state_in;

   // a holds the larger operand, then the running sum, then the normalized value
   logic [DP_W-1:0]     a_ff, a_in;
   logic [DP_W-1:0]     b_ff, b_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic signed [EW-1:0] exp_ff, exp_in;
   logic                sub_ff, sub_in;
   logic                neg_ff, neg_in;
   logic                nz_ff, nz_in;
   fasn_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   fasn_pkg::adder_ctl_type adder_ctl;
   logic                sum_bit;

   // request decode
   logic                a_big;
   logic [EB-1:0]       exp_diff;
   logic [EB-1:0]       exp_big;
   logic [CMP_W-1:0]    diff_ext;
   logic [DP_W-1:0]     sig_a;
   logic [DP_W-1:0]     sig_b;

   fasn_serial_adder u_adder (
      .clock   (clock),
      .ctl     (adder_ctl),
      .a_bit   (a_ff[0]),
      .b_bit   (b_ff[0]),
      .sum_bit (sum_bit)
   );

   // significand 1.f placed with the hidden one at bit 2*FRAC_BITS
   assign sig_a = {1'b0, 1'b1, req_data.frac_a, {FB{1'b0}}};
   assign sig_b = {1'b0, 1'b1, req_data.frac_b, {FB{1'b0}}};

   // a is the larger magnitude, so a - b never goes negative
   assign a_big = (req_data.exp_a > req_data.exp_b) ||
                  ((req_data.exp_a == req_data.exp_b) &&
                   (req_data.frac_a >= req_data.frac_b));
   assign exp_diff = a_big ? (req_data.exp_a - req_data.exp_b)
                           : (req_data.exp_b - req_data.exp_a);
   assign exp_big  = a_big ? req_data.exp_a : req_data.exp_b;
   assign diff_ext = CMP_W'(exp_diff);

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      cnt_in       = cnt_ff;
      exp_in       = exp_ff;
      sub_in       = sub_ff;
      neg_in       = neg_ff;
      nz_in        = nz_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;

      adder_ctl.clear    = 1'b0;
      adder_ctl.enable   = 1'b0;
      adder_ctl.subtract = sub_ff;

      case (state_ff)
         fasn_pkg::S_IDLE: begin
            if (start) begin
               a_in   = a_big ? sig_a : sig_b;
               b_in   = a_big ? sig_b : sig_a;
               // gaps past the datapath width flush the smaller operand
               if (diff_ext >= CMP_W'(DP_W)) begin
                  cnt_in = CNT_W'(DP_W);
               end else begin
                  cnt_in = diff_ext[CNT_W-1:0];
               end
               // exponent of the msb before normalization shifts
               exp_in   = signed'(EW'(exp_big) + EW'(1));
               sub_in   = ~req_data.is_add;
               neg_in   = ~req_data.is_add & ~a_big;
               state_in = fasn_pkg::S_ALIGN;
            end
         end

         fasn_pkg::S_ALIGN: begin
            if (cnt_ff == '0) begin
               // preset carry and zero flag, then walk all bits lsb first
               adder_ctl.clear = 1'b1;
               nz_in           = 1'b0;
               cnt_in          = CNT_W'(DP_W - 1);
               state_in        = fasn_pkg::S_ADD;
            end else begin
               b_in   = b_ff >> 1;
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end

         fasn_pkg::S_ADD: begin
            adder_ctl.enable = 1'b1;
            // sum bits enter at the top of a as its bits leave at the bottom
            a_in  = {sum_bit, a_ff[DP_W-1:1]};
            b_in  = b_ff >> 1;
            nz_in = nz_ff | sum_bit;
            if (cnt_ff == '0) begin
               state_in = (nz_ff | sum_bit) ? fasn_pkg::S_NORM : fasn_pkg::S_DONE;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end

         fasn_pkg::S_NORM: begin
            // one left shift per cycle until the leading one reaches the top
            if (a_ff[DP_W-1]) begin
               state_in = fasn_pkg::S_DONE;
            end else begin
               a_in   = a_ff << 1;
               exp_in = exp_ff - EW'(1);
            end
         end

         fasn_pkg::S_DONE: begin
            rsp_in.status          = fasn_pkg::ST_NORMAL;
            rsp_in.result_negative = neg_ff;
            rsp_in.result_fraction = a_ff[DP_W-2 -: FB];
            rsp_in.result_exponent = signed'(exp_ff[EB-1:0]);
            if (!nz_ff) begin
               rsp_in.status          = fasn_pkg::ST_ZERO;
               rsp_in.result_negative = 1'b0;
               rsp_in.result_fraction = '0;
               rsp_in.result_exponent = '0;
            end else if (exp_ff < fasn_pkg::EXP_MIN) begin
               rsp_in.status          = fasn_pkg::ST_UNDER;
               rsp_in.result_fraction = '0;
               rsp_in.result_exponent = '0;
            end else if (exp_ff > fasn_pkg::EXP_MAX) begin
               rsp_in.status          = fasn_pkg::ST_OVER;
               rsp_in.result_fraction = '0;
               rsp_in.result_exponent = '0;
            end
            rsp_valid_in = 1'b1;
            state_in     = fasn_pkg::S_IDLE;
         end

         default: begin
            state_in = fasn_pkg::S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fasn_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
      exp_ff <= exp_in;
      sub_ff <= sub_in;
      neg_ff <= neg_in;
      nz_ff  <= nz_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != fasn_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // an accepted request keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not make the block busy");

   // the strobe comes only as the block returns to idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // normalization only runs on a nonzero magnitude
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == fasn_pkg::S_NORM) |-> (a_ff != '0))
      else $error("normalize loop entered with zero magnitude");

   // alignment count never exceeds the datapath width
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == fasn_pkg::S_ALIGN) |-> (cnt_ff <= CNT_W'(DP_W)))
      else $error("alignment count out of range");

   // a zero result carries no sign and no exponent
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == fasn_pkg::ST_ZERO)) |->
      (!rsp_data.result_negative && (rsp_data.result_exponent == '0)))
      else $error("zero result with sign or exponent set");

endmodule
